[sv/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants for the midpoint circle rasteriser: command
// kinds, the command record passed from front to back and queue sizing.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // default radius width
  localparam int unsigned RadiusBitsDefault = 14;

  // command queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  // output coordinate width
  localparam int unsigned CoordW = 16;

  // input field widths
  localparam int unsigned CenterW = 15;
  localparam int unsigned RadiusInW = 14;

  // input function codes
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_e;

  // what the back end has to emit for one command
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_DONE  = 2'd2
  } cmd_kind_e;

  // one queued command: centre and the two offsets, already wrapped to 16 bits
  typedef struct packed {
    cmd_kind_e                  kind;
    logic signed [CenterW-1:0]  cx;
    logic signed [CenterW-1:0]  cy;
    logic        [CoordW-1:0]   u;
    logic        [CoordW-1:0]   v;
  } cmd_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[sv/mcr_front.sv]
// ----------------------------------------------------------------------------
// mcr_front
// Accepts input items, keeps the circle state (centre, x, y, decision error)
// and turns each item into one command for the pixel back end.
// ----------------------------------------------------------------------------
module mcr_front
  import mcr_pkg::*;
#(
  parameter int unsigned RADIUS_BITS = RadiusBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic signed [CenterW-1:0]   center_x_i,
  input  logic signed [CenterW-1:0]   center_y_i,
  input  logic        [RadiusInW-1:0] radius_i,
  input  queue_status_t               q_status_i,
  output logic                        push_o,
  output cmd_t                        push_cmd_o
);

  localparam int unsigned RB = RADIUS_BITS;
  localparam int unsigned EW = RADIUS_BITS + 3;
  localparam logic signed [EW-1:0] ErrOne   = EW'(1);
  localparam logic signed [EW-1:0] ErrThree = EW'(3);
  localparam logic signed [EW-1:0] ErrFive  = EW'(5);

  logic signed [CenterW-1:0] cx_q, cx_d;
  logic signed [CenterW-1:0] cy_q, cy_d;
  logic        [RB-1:0]      x_q, x_d;
  logic        [RB-1:0]      y_q, y_d;
  logic signed [EW-1:0]      err_q, err_d;
  logic                      active_q, active_d;

  logic                      accept;
  logic [RB+RadiusInW-1:0]   r_ext;
  logic [RB-1:0]             r;
  logic [RB-1:0]             x_inc;
  logic [RB-1:0]             y_dec;
  logic signed [EW-1:0]      diff_s;
  logic                      err_nonneg;
  logic [RB+CoordW-1:0]      u_ext;
  logic [RB+CoordW-1:0]      v_ext;

  assign accept     = in_valid_i && !q_status_i.full;
  assign in_stall_o = q_status_i.full;

  // radius trimmed or widened to the internal width
  assign r_ext = {{RB{1'b0}}, radius_i};
  assign r     = r_ext[RB-1:0];

  // loop arithmetic
  assign x_inc      = x_q + RB'(1);
  assign y_dec      = y_q - RB'(1);
  assign diff_s     = signed'({3'b000, x_q}) - signed'({3'b000, y_q});
  assign err_nonneg = !err_q[EW-1];

  // state update and command build
  always_comb begin
    cx_d       = cx_q;
    cy_d       = cy_q;
    x_d        = x_q;
    y_d        = y_q;
    err_d      = err_q;
    active_d   = active_q;
    push_o     = 1'b0;
    u_ext      = '0;
    v_ext      = '0;
    push_cmd_o.kind = CMD_DONE;
    push_cmd_o.cx   = cx_q;
    push_cmd_o.cy   = cy_q;
    if (accept) begin
      push_o = 1'b1;
      if (func_i == FUNC_START) begin
        cx_d     = center_x_i;
        cy_d     = center_y_i;
        x_d      = '0;
        y_d      = r;
        err_d    = ErrOne - signed'({3'b000, r});
        active_d = 1'b1;
        push_cmd_o.kind = CMD_START;
        push_cmd_o.cx   = center_x_i;
        push_cmd_o.cy   = center_y_i;
        v_ext    = {{CoordW{1'b0}}, r};
      end else if (!active_q || (x_q >= y_q)) begin
        active_d = 1'b0;
        push_cmd_o.kind = CMD_DONE;
      end else begin
        x_d = x_inc;
        push_cmd_o.kind = CMD_STEP;
        u_ext = {{CoordW{1'b0}}, x_inc};
        if (err_nonneg) begin
          // y steps inwards: err + 2(x - y) + 5
          y_d   = y_dec;
          err_d = err_q + (diff_s <<< 1) + ErrFive;
          v_ext = {{CoordW{1'b0}}, y_dec};
        end else begin
          // y holds: err + 2x + 3
          err_d = err_q + signed'({2'b00, x_q, 1'b0}) + ErrThree;
          v_ext = {{CoordW{1'b0}}, y_q};
        end
      end
    end
    push_cmd_o.u = u_ext[CoordW-1:0];
    push_cmd_o.v = v_ext[CoordW-1:0];
  end

  // circle state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      err_q    <= '0;
      active_q <= 1'b0;
    end else begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      x_q      <= x_d;
      y_q      <= y_d;
      err_q    <= err_d;
      active_q <= active_d;
    end
  end

endmodule

[sv/mcr_queue.sv]
// ----------------------------------------------------------------------------
// mcr_queue
// Short first-in first-out command queue between the front and the back end.
// ----------------------------------------------------------------------------
module mcr_queue
  import mcr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          push_cmd_i,
  input  logic          pop_i,
  output cmd_t          head_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = (count_q == CntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = entry_q[rd_ptr_q];

  // pointer and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[sv/mcr_back.sv]
// ----------------------------------------------------------------------------
// mcr_back
// Pixel back end: walks each queued command and emits its mirrored pixels,
// one per cycle unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module mcr_back
  import mcr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      head_i,
  input  queue_status_t             q_status_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [CoordW-1:0]  pixel_x_o,
  output logic signed [CoordW-1:0]  pixel_y_o,
  output logic                      last_o,
  output logic                      done_res_o
);

  logic [2:0]               cnt_q, cnt_d;
  logic                     valid_q, valid_d;
  logic signed [CoordW-1:0] px_q, px_d;
  logic signed [CoordW-1:0] py_q, py_d;
  logic                     last_q, last_d;
  logic                     done_q, done_d;

  logic                     load;
  logic [2:0]               oct;
  logic                     is_last;
  logic [CoordW-1:0]        a;
  logic [CoordW-1:0]        b;
  logic signed [CoordW-1:0] cx16;
  logic signed [CoordW-1:0] cy16;

  assign load = !q_status_i.empty && (!valid_q || !out_stall_i);
  assign cx16 = {head_i.cx[CenterW-1], head_i.cx};
  assign cy16 = {head_i.cy[CenterW-1], head_i.cy};

  // octant selection: bit 2 swaps x and y, bit 1 negates y, bit 0 negates x
  always_comb begin
    oct     = cnt_q;
    is_last = 1'b0;
    case (head_i.kind)
      CMD_START: begin
        oct     = {cnt_q[1], cnt_q[0] & ~cnt_q[1], cnt_q[0] & cnt_q[1]};
        is_last = (cnt_q[1:0] == 2'b11);
      end
      CMD_STEP: begin
        oct     = cnt_q;
        is_last = (cnt_q == 3'b111);
      end
      CMD_DONE: begin
        is_last = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
    a = oct[2] ? head_i.v : head_i.u;
    b = oct[2] ? head_i.u : head_i.v;
  end

  // next output and sequence counter
  always_comb begin
    cnt_d   = cnt_q;
    px_d    = px_q;
    py_d    = py_q;
    last_d  = last_q;
    done_d  = done_q;
    valid_d = valid_q && out_stall_i;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      last_d  = is_last;
      pop_o   = is_last;
      cnt_d   = is_last ? 3'd0 : cnt_q + 3'd1;
      if (head_i.kind == CMD_DONE) begin
        px_d   = '0;
        py_d   = '0;
        done_d = 1'b1;
      end else begin
        px_d   = oct[0] ? cx16 - signed'(a) : cx16 + signed'(a);
        py_d   = oct[1] ? cy16 - signed'(b) : cy16 + signed'(b);
        done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign out_valid_o = valid_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign last_o      = last_q;
  assign done_res_o  = done_q;

endmodule

[sv/midpoint_circle_rasterizer_top.sv]
// Path: an item is queued as a command, then its results pass the registered output
//   stage; the first waits while earlier commands are still being emitted.
// Throughput: a pixel per cycle unless stalled; a step emits 8, a start 4, a done 1;
//   the front takes an item each cycle while the two-entry command queue has room.
// Reset: asynchronous, active low; clears the circle state to idle, empties the
//   queue and drops any pending output.
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top
// Incremental midpoint circle generator: front keeps the loop state, back
// emits the octant-mirrored pixels.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_top
  import mcr_pkg::*;
#(
  parameter int unsigned RADIUS_BITS = RadiusBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic signed [CenterW-1:0]   center_x_i,
  input  logic signed [CenterW-1:0]   center_y_i,
  input  logic        [RadiusInW-1:0] radius_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [CoordW-1:0]    pixel_x_o,
  output logic signed [CoordW-1:0]    pixel_y_o,
  output logic                        last_o,
  output logic                        done_res_o
);

  queue_status_t q_status;
  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          head;

  // classification and loop state
  mcr_front #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // command queue
  mcr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  // pixel emission
  mcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_o      (last_o),
    .done_res_o  (done_res_o)
  );

endmodule

[sv/mcr_checker.sv]
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks for the circle rasteriser, bound to the top level.
// ----------------------------------------------------------------------------
module mcr_checker
  import mcr_pkg::*;
(
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [CoordW-1:0]    pixel_x_o,
  input logic signed [CoordW-1:0]    pixel_y_o,
  input logic                        last_o,
  input logic                        done_res_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a done result closes its item
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> last_o)
    else $error("done result without last");

  // a done result carries zero coordinates
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> (pixel_x_o == '0) && (pixel_y_o == '0))
    else $error("done result with non-zero pixel");

  // no result shows in the cycle after reset releases
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight out of reset");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pixel_x_o   (pixel_x_o),
  .pixel_y_o   (pixel_y_o),
  .last_o      (last_o),
  .done_res_o  (done_res_o)
);
